>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the source text tokenizer
// Token kind codes, scan modes and the token record passed front to back.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int OffW = 16;
  localparam logic [OffW-1:0] OffMax = {OffW{1'b1}};
  localparam logic [OffW-1:0] LenOne = OffW'(1);
  localparam logic [OffW-1:0] LenTwo = OffW'(2);

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_IDENT, M_NUM, M_NUMDOT, M_STR, M_COMMENT
  } scan_mode_t;

  localparam logic [5:0] K_SEMI = 6'd0,  K_LPAR = 6'd1,  K_RPAR = 6'd2;
  localparam logic [5:0] K_LBRC = 6'd3,  K_RBRC = 6'd4,  K_EQEQ = 6'd5;
  localparam logic [5:0] K_ASGN = 6'd6,  K_PLUS = 6'd7,  K_ARROW = 6'd8;
  localparam logic [5:0] K_MINUS = 6'd9, K_POW = 6'd10,  K_STAR = 6'd11;
  localparam logic [5:0] K_CMT = 6'd12,  K_SLASH = 6'd13, K_LAND = 6'd14;
  localparam logic [5:0] K_AMP = 6'd15,  K_LOR = 6'd16,  K_BAR = 6'd17;
  localparam logic [5:0] K_NE = 6'd18,   K_NOT = 6'd19,  K_TILDE = 6'd20;
  localparam logic [5:0] K_CARET = 6'd21, K_LE = 6'd22,  K_LT = 6'd23;
  localparam logic [5:0] K_GE = 6'd24,   K_GT = 6'd25,   K_BOOL = 6'd26;
  localparam logic [5:0] K_IF = 6'd27,   K_ELSE = 6'd28, K_WHILE = 6'd29;
  localparam logic [5:0] K_IDENT = 6'd30, K_NUM = 6'd31, K_STR = 6'd32;
  localparam logic [5:0] K_BAD = 6'd33,  K_UNTERM = 6'd34, K_END = 6'd35;

  // one token as it leaves the scanner
  typedef struct packed {
    logic [5:0]      kind;
    logic [OffW-1:0] start;
    logic [OffW-1:0] len;
    logic            last;
  } token_t;

  function automatic logic [OffW-1:0] sat_inc(input logic [OffW-1:0] v);
    sat_inc = (v == OffMax) ? v : v + 1'b1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] p);
    case (p)
      "=": single_op = K_ASGN;
      "-": single_op = K_MINUS;
      "*": single_op = K_STAR;
      "/": single_op = K_SLASH;
      "&": single_op = K_AMP;
      "|": single_op = K_BAR;
      "!": single_op = K_NOT;
      "<": single_op = K_LT;
      default: single_op = K_GT;
    endcase
  endfunction

  // pair kind; K_SEMI (zero) when the pair is no operator
  function automatic logic [5:0] pair_op(input logic [7:0] p, input logic [7:0] c);
    pair_op = K_SEMI;
    if (p == "=" && c == "=") pair_op = K_EQEQ;
    if (p == "-" && c == ">") pair_op = K_ARROW;
    if (p == "*" && c == "*") pair_op = K_POW;
    if (p == "&" && c == "&") pair_op = K_LAND;
    if (p == "|" && c == "|") pair_op = K_LOR;
    if (p == "!" && c == "=") pair_op = K_NE;
    if (p == "<" && c == "=") pair_op = K_LE;
    if (p == ">" && c == "=") pair_op = K_GE;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [39:0] kb,
                                            input logic [OffW-1:0] len);
    ident_kind = K_IDENT;
    if ((len == 4 && kb == 40'h65757274) || (len == 5 && kb == 40'h65736c6166))
      ident_kind = K_BOOL;
    else if (len == 2 && kb == 40'h6669) ident_kind = K_IF;
    else if (len == 4 && kb == 40'h65736c65) ident_kind = K_ELSE;
    else if (len == 5 && kb == 40'h656c696877) ident_kind = K_WHILE;
    else if (len == 3 && kb == 40'h646e61) ident_kind = K_LAND;
    else if (len == 2 && kb == 40'h726f) ident_kind = K_LOR;
    else if (len == 3 && kb == 40'h746f6e) ident_kind = K_NOT;
  endfunction

endpackage

>>> rtl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan: front end of the tokenizer
// Takes one byte per cycle while the queue has room for three tokens, runs the
// scan state and writes up to three tokens per byte into the token queue.
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          char_code,
  input  logic                is_last,
  input  logic [1:0]          free_slots,
  output logic                in_take,
  output logic [1:0]          push_count,
  output stt_pkg::token_t     push_tok [3]
);

  stt_pkg::scan_mode_t             scan_mode, scan_mode_next;
  logic [7:0]                      pend_char, pend_char_next;
  logic [stt_pkg::OffW-1:0]        tok_start, tok_start_next;
  logic [stt_pkg::OffW-1:0]        tok_len, tok_len_next;
  logic [39:0]                     kbuf, kbuf_next;
  logic [stt_pkg::OffW-1:0]        byte_pos, byte_pos_next;

  // a byte needs room for three tokens in the worst case
  assign in_take = (free_slots == 2'd3);

  // scan logic: one byte in, up to three tokens out
  always_comb begin
    logic            rescan;
    logic [5:0]      k;
    stt_pkg::token_t t;
    logic [stt_pkg::OffW-1:0] pos_after;
    rescan = 1'b0;
    k = '0;
    t = '0;
    scan_mode_next = scan_mode;
    pend_char_next = pend_char;
    tok_start_next = tok_start;
    tok_len_next = tok_len;
    kbuf_next = kbuf;
    push_count = '0;
    for (int i = 0; i < 3; i++) push_tok[i] = '0;
    pos_after = stt_pkg::sat_inc(byte_pos);

    // continue the pending token
    unique case (scan_mode)
      stt_pkg::M_IDLE: rescan = 1'b1;
      stt_pkg::M_OP: begin
        scan_mode_next = stt_pkg::M_IDLE;
        k = stt_pkg::pair_op(pend_char, char_code);
        if (pend_char == "/" && char_code == "/") begin
          scan_mode_next = stt_pkg::M_COMMENT;
          tok_len_next = stt_pkg::LenTwo;
        end else if (k != stt_pkg::K_SEMI) begin
          t = '{k, tok_start, stt_pkg::LenTwo, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end else begin
          t = '{stt_pkg::single_op(pend_char), tok_start, stt_pkg::LenOne, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
          rescan = 1'b1;
        end
      end
      stt_pkg::M_IDENT: begin
        if (stt_pkg::is_alpha(char_code) || stt_pkg::is_digit(char_code)) begin
          if (tok_len < 5) kbuf_next[8*tok_len[2:0] +: 8] = char_code;
          tok_len_next = stt_pkg::sat_inc(tok_len);
        end else begin
          scan_mode_next = stt_pkg::M_IDLE;
          t = '{stt_pkg::ident_kind(kbuf, tok_len), tok_start, tok_len, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
          rescan = 1'b1;
        end
      end
      stt_pkg::M_NUM, stt_pkg::M_NUMDOT: begin
        if (stt_pkg::is_digit(char_code) ||
            (char_code == "." && scan_mode == stt_pkg::M_NUM)) begin
          if (char_code == ".") scan_mode_next = stt_pkg::M_NUMDOT;
          tok_len_next = stt_pkg::sat_inc(tok_len);
        end else begin
          scan_mode_next = stt_pkg::M_IDLE;
          t = '{stt_pkg::K_NUM, tok_start, tok_len, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
          rescan = 1'b1;
        end
      end
      stt_pkg::M_STR: begin
        tok_len_next = stt_pkg::sat_inc(tok_len);
        if (char_code == "'") begin
          scan_mode_next = stt_pkg::M_IDLE;
          t = '{stt_pkg::K_STR, tok_start, tok_len_next, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end
      end
      stt_pkg::M_COMMENT: begin
        if (char_code == 8'h0a) begin
          scan_mode_next = stt_pkg::M_IDLE;
          t = '{stt_pkg::K_CMT, tok_start, tok_len, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end else begin
          tok_len_next = stt_pkg::sat_inc(tok_len);
        end
      end
      default: begin
        scan_mode_next = stt_pkg::M_IDLE;
        rescan = 1'b1;
      end
    endcase

    // start a new token from idle
    if (rescan) begin
      k = stt_pkg::K_BAD;
      case (char_code)
        " ", 8'h0a: k = stt_pkg::K_END;
        ";": k = stt_pkg::K_SEMI;
        "(": k = stt_pkg::K_LPAR;
        ")": k = stt_pkg::K_RPAR;
        "{": k = stt_pkg::K_LBRC;
        "}": k = stt_pkg::K_RBRC;
        "+": k = stt_pkg::K_PLUS;
        "~": k = stt_pkg::K_TILDE;
        "^": k = stt_pkg::K_CARET;
        "=", "-", "*", "/", "&", "|", "!", "<", ">": begin
          k = stt_pkg::K_END;
          scan_mode_next = stt_pkg::M_OP;
          pend_char_next = char_code;
        end
        default: begin
          if (stt_pkg::is_alpha(char_code)) begin
            k = stt_pkg::K_END;
            scan_mode_next = stt_pkg::M_IDENT;
          end else if (stt_pkg::is_digit(char_code)) begin
            k = stt_pkg::K_END;
            scan_mode_next = stt_pkg::M_NUM;
          end else if (char_code == "'") begin
            k = stt_pkg::K_END;
            scan_mode_next = stt_pkg::M_STR;
          end
        end
      endcase
      if (scan_mode_next != stt_pkg::M_IDLE) begin
        tok_start_next = byte_pos;
        tok_len_next = stt_pkg::LenOne;
        kbuf_next = (scan_mode_next == stt_pkg::M_IDENT) ? {32'd0, char_code} : '0;
      end else if (k != stt_pkg::K_END) begin
        // K_END here only marks a dropped blank
        t = '{k, byte_pos, stt_pkg::LenOne, 1'b0};
        push_tok[push_count] = t; push_count = push_count + 1'b1;
      end
    end

    // flush and end marker
    if (is_last) begin
      unique case (scan_mode_next)
        stt_pkg::M_OP: begin
          t = '{stt_pkg::single_op(pend_char_next), tok_start_next,
                stt_pkg::LenOne, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end
        stt_pkg::M_IDENT: begin
          t = '{stt_pkg::ident_kind(kbuf_next, tok_len_next), tok_start_next,
                tok_len_next, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end
        stt_pkg::M_NUM, stt_pkg::M_NUMDOT: begin
          t = '{stt_pkg::K_NUM, tok_start_next, tok_len_next, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end
        stt_pkg::M_STR: begin
          t = '{stt_pkg::K_UNTERM, tok_start_next, tok_len_next, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end
        stt_pkg::M_COMMENT: begin
          t = '{stt_pkg::K_CMT, tok_start_next, tok_len_next, 1'b0};
          push_tok[push_count] = t; push_count = push_count + 1'b1;
        end
        default: ;
      endcase
      t = '{stt_pkg::K_END, pos_after, '0, 1'b0};
      push_tok[push_count] = t; push_count = push_count + 1'b1;
      scan_mode_next = stt_pkg::M_IDLE;
      pend_char_next = '0;
      tok_start_next = '0;
      tok_len_next = '0;
      kbuf_next = '0;
      byte_pos_next = '0;
    end else begin
      byte_pos_next = pos_after;
    end

    // mark the final token of this byte
    if (push_count != 0) push_tok[push_count - 1'b1].last = 1'b1;
    if (!(in_valid && in_take)) push_count = '0;
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= stt_pkg::M_IDLE;
      pend_char <= '0;
      tok_start <= '0;
      tok_len <= '0;
      kbuf <= '0;
      byte_pos <= '0;
    end else if (in_valid && in_take) begin
      scan_mode <= scan_mode_next;
      pend_char <= pend_char_next;
      tok_start <= tok_start_next;
      tok_len <= tok_len_next;
      kbuf <= kbuf_next;
      byte_pos <= byte_pos_next;
    end
  end

endmodule

>>> rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue: token queue and output stage
// Eight-entry queue that takes up to three tokens a cycle and hands one a
// cycle to the output register when that register is empty or being taken.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  stt_pkg::token_t     push_tok [3],
  output logic [1:0]          free_slots,
  output logic                out_valid,
  input  logic                out_stall,
  output stt_pkg::token_t     out_tok
);

  stt_pkg::token_t q [8];
  logic [2:0] rd_ptr, wr_ptr;
  logic [3:0] count;
  logic       pop, load;

  // room for a full byte's worth only when at least three entries are free
  assign free_slots = (count <= 4'd5) ? 2'd3 : 2'd0;

  // output register loads when empty or being taken
  assign load = !out_valid || !out_stall;
  assign pop  = load && (count != 0);

  // queue storage and pointers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_count) q[wr_ptr + 3'(i)] <= push_tok[i];
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + 3'(push_count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 4'(push_count) - 4'(pop);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= (count != 0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_tok <= q[rd_ptr];
  end

endmodule

>>> rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte-stream lexer
// Scanner front end feeding a token queue and an output register.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the token queue has room for three
// tokens; a byte yields zero to three tokens, which leave one per cycle while
// the output is not stalled, so the sustained rate is one byte a cycle when
// tokens average no more than one per byte. An accepted byte's tokens go
// into the token queue, then through the output register behind older ones.
module source_text_tokenizer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  input  logic                     is_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [5:0]               token_kind,
  output logic [stt_pkg::OffW-1:0] start_offset,
  output logic [stt_pkg::OffW-1:0] token_length,
  output logic                     last_of_run
);

  logic            in_take;
  logic [1:0]      push_count, free_slots;
  stt_pkg::token_t push_tok [3];
  stt_pkg::token_t out_tok;

  stt_scan u_scan (
    .clk, .rst, .in_valid, .char_code, .is_last, .free_slots,
    .in_take, .push_count, .push_tok
  );

  stt_queue u_queue (
    .clk, .rst, .push_count, .push_tok, .free_slots,
    .out_valid, .out_stall, .out_tok
  );

  assign in_stall     = !in_take;
  assign token_kind   = out_tok.kind;
  assign start_offset = out_tok.start;
  assign token_length = out_tok.len;
  assign last_of_run  = out_tok.last;

  // a byte at the end of text always yields the end marker
  a_last_push: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && is_last) |-> push_count != 2'd0)
    else $error("end of text produced no token");

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    u_queue.count <= 4'd8)
    else $error("token queue overflow");

  // end marker has zero length
  a_end_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind == stt_pkg::K_END) |-> token_length == '0)
    else $error("end marker with nonzero length");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the source text tokenizer
// Feeds byte streams through a valid/stall request channel, predicts the
// tokens of each byte and checks every token field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WdogLimit = 4000;
  localparam int HoldLen = 200;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } src_byte_t;

  typedef struct {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  source_text_tokenizer i_dut (.*);

  always #6 clk = ~clk;

  src_byte_t byte_q[$];
  tok_t      token_q[$];
  int        errors = 0;
  int        send_idle_pct = 25;
  int        recv_idle_pct = 50;
  bit        hold_req = 0;
  bit        hold_started = 0;
  int        hold_cycles = 0;
  int        quiet_cycles = 0;
  logic      in_taken = 1'b0;

  // predictor state
  stt_pkg::scan_mode_t p_mode;
  logic [7:0]  p_opch;
  logic [15:0] p_start, p_len, p_pos;
  logic [39:0] p_kbuf;

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] op1_kind(logic [7:0] p);
    case (p)
      "=": return stt_pkg::K_ASGN;
      "-": return stt_pkg::K_MINUS;
      "*": return stt_pkg::K_STAR;
      "/": return stt_pkg::K_SLASH;
      "&": return stt_pkg::K_AMP;
      "|": return stt_pkg::K_BAR;
      "!": return stt_pkg::K_NOT;
      "<": return stt_pkg::K_LT;
      default: return stt_pkg::K_GT;
    endcase
  endfunction

  function automatic logic [5:0] op2_kind(logic [7:0] p, logic [7:0] c);
    if (c == "=") begin
      case (p)
        "=": return stt_pkg::K_EQEQ;
        "!": return stt_pkg::K_NE;
        "<": return stt_pkg::K_LE;
        ">": return stt_pkg::K_GE;
        default: ;
      endcase
    end
    if (p == "-" && c == ">") return stt_pkg::K_ARROW;
    if (p == "*" && c == "*") return stt_pkg::K_POW;
    if (p == "&" && c == "&") return stt_pkg::K_LAND;
    if (p == "|" && c == "|") return stt_pkg::K_LOR;
    return stt_pkg::K_SEMI;
  endfunction

  function automatic logic [39:0] pack_word(string w);
    logic [39:0] r = '0;
    for (int i = 0; i < w.len(); i++) r[8*i +: 8] = w[i];
    return r;
  endfunction

  function automatic logic [5:0] word_kind();
    if ((p_len == 4 && p_kbuf == pack_word("true")) ||
        (p_len == 5 && p_kbuf == pack_word("false"))) return stt_pkg::K_BOOL;
    if (p_len == 2 && p_kbuf == pack_word("if")) return stt_pkg::K_IF;
    if (p_len == 4 && p_kbuf == pack_word("else")) return stt_pkg::K_ELSE;
    if (p_len == 5 && p_kbuf == pack_word("while")) return stt_pkg::K_WHILE;
    if (p_len == 3 && p_kbuf == pack_word("and")) return stt_pkg::K_LAND;
    if (p_len == 2 && p_kbuf == pack_word("or")) return stt_pkg::K_LOR;
    if (p_len == 3 && p_kbuf == pack_word("not")) return stt_pkg::K_NOT;
    return stt_pkg::K_IDENT;
  endfunction

  task automatic lex_reset();
    p_mode = stt_pkg::M_IDLE; p_opch = '0; p_start = '0; p_len = '0;
    p_kbuf = '0; p_pos = '0;
  endtask

  function automatic void push_tok(input logic [5:0] k, input logic [15:0] s,
                                   input logic [15:0] l, inout tok_t run[$]);
    tok_t t;
    t.kind = k; t.start = s; t.len = l; t.last = 1'b0;
    run = {run, t};
  endfunction

  task automatic begin_tok(input stt_pkg::scan_mode_t m, input logic [15:0] s);
    p_mode = m; p_start = s; p_len = 16'd1; p_kbuf = '0;
  endtask

  task automatic lex_idle(input logic [7:0] c, input logic [15:0] s,
                          inout tok_t run[$]);
    case (c)
      " ", "\n": ;
      ";": push_tok(stt_pkg::K_SEMI, s, 16'd1, run);
      "(": push_tok(stt_pkg::K_LPAR, s, 16'd1, run);
      ")": push_tok(stt_pkg::K_RPAR, s, 16'd1, run);
      "{": push_tok(stt_pkg::K_LBRC, s, 16'd1, run);
      "}": push_tok(stt_pkg::K_RBRC, s, 16'd1, run);
      "+": push_tok(stt_pkg::K_PLUS, s, 16'd1, run);
      "~": push_tok(stt_pkg::K_TILDE, s, 16'd1, run);
      "^": push_tok(stt_pkg::K_CARET, s, 16'd1, run);
      "=", "-", "*", "/", "&", "|", "!", "<", ">": begin
        begin_tok(stt_pkg::M_OP, s);
        p_opch = c;
      end
      default: begin
        if (alpha_c(c)) begin
          begin_tok(stt_pkg::M_IDENT, s);
          p_kbuf = {32'd0, c};
        end else if (digit_c(c)) begin
          begin_tok(stt_pkg::M_NUM, s);
        end else if (c == "'") begin
          begin_tok(stt_pkg::M_STR, s);
        end else begin
          push_tok(stt_pkg::K_BAD, s, 16'd1, run);
        end
      end
    endcase
  endtask

  // returns 1 when the byte is consumed by the pending token
  function automatic bit lex_busy(input logic [7:0] c, inout tok_t run[$]);
    logic [5:0] k;
    case (p_mode)
      stt_pkg::M_OP: begin
        p_mode = stt_pkg::M_IDLE;
        if (p_opch == "/" && c == "/") begin
          p_mode = stt_pkg::M_COMMENT;
          p_len = 16'd2;
          return 1;
        end
        k = op2_kind(p_opch, c);
        if (k != stt_pkg::K_SEMI) begin
          push_tok(k, p_start, 16'd2, run);
          return 1;
        end
        push_tok(op1_kind(p_opch), p_start, 16'd1, run);
        return 0;
      end
      stt_pkg::M_IDENT: begin
        if (alpha_c(c) || digit_c(c)) begin
          if (p_len < 5) p_kbuf[8*p_len[2:0] +: 8] = c;
          p_len = inc16(p_len);
          return 1;
        end
        p_mode = stt_pkg::M_IDLE;
        push_tok(word_kind(), p_start, p_len, run);
        return 0;
      end
      stt_pkg::M_NUM, stt_pkg::M_NUMDOT: begin
        if (digit_c(c) || (c == "." && p_mode == stt_pkg::M_NUM)) begin
          if (c == ".") p_mode = stt_pkg::M_NUMDOT;
          p_len = inc16(p_len);
          return 1;
        end
        p_mode = stt_pkg::M_IDLE;
        push_tok(stt_pkg::K_NUM, p_start, p_len, run);
        return 0;
      end
      stt_pkg::M_STR: begin
        p_len = inc16(p_len);
        if (c == "'") begin
          p_mode = stt_pkg::M_IDLE;
          push_tok(stt_pkg::K_STR, p_start, p_len, run);
        end
        return 1;
      end
      stt_pkg::M_COMMENT: begin
        if (c == "\n") begin
          p_mode = stt_pkg::M_IDLE;
          push_tok(stt_pkg::K_CMT, p_start, p_len, run);
        end else begin
          p_len = inc16(p_len);
        end
        return 1;
      end
      default: begin
        p_mode = stt_pkg::M_IDLE;
        return 0;
      end
    endcase
  endfunction

  // predicts the tokens one accepted byte causes
  task automatic predict_tokens(input logic [7:0] c, input logic fin);
    tok_t run[$];
    logic [15:0] s;
    s = p_pos;
    if (p_mode == stt_pkg::M_IDLE || !lex_busy(c, run)) lex_idle(c, s, run);
    p_pos = inc16(p_pos);
    if (fin) begin
      case (p_mode)
        stt_pkg::M_OP: push_tok(op1_kind(p_opch), p_start, 16'd1, run);
        stt_pkg::M_IDENT: push_tok(word_kind(), p_start, p_len, run);
        stt_pkg::M_NUM, stt_pkg::M_NUMDOT:
          push_tok(stt_pkg::K_NUM, p_start, p_len, run);
        stt_pkg::M_STR: push_tok(stt_pkg::K_UNTERM, p_start, p_len, run);
        stt_pkg::M_COMMENT: push_tok(stt_pkg::K_CMT, p_start, p_len, run);
        default: ;
      endcase
      push_tok(stt_pkg::K_END, p_pos, 16'd0, run);
      lex_reset();
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    token_q = {token_q, run};
  endtask

  // stimulus helpers
  task automatic add_text(input string s, input bit fin);
    src_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.ch = s[i];
      b.fin = fin && (i == s.len() - 1);
      byte_q = {byte_q, b};
    end
  endtask

  task automatic add_byte(input logic [7:0] c, input logic fin);
    src_byte_t b;
    b.ch = c; b.fin = fin;
    byte_q = {byte_q, b};
  endtask

  function automatic string rand_lexeme();
    string pool[] = '{"true", "false", "if", "else", "while", "and", "or",
                      "not", "x_1", "Foo9", "whilex", "tru", "12", "3.14",
                      "1.2.3", "'ab c'", "// note\n", "==", "!=", "<=", ">=",
                      "->", "**", "&&", "||", "=", "-", "*", "/", "&", "|",
                      "!", "<", ">", ";", "(", ")", "{", "}", "+", "~", "^",
                      " ", "\n", "_", "'", "7."};
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  task automatic add_random(input int nbytes);
    string s;
    int n = 0;
    while (n < nbytes) begin
      if ($urandom_range(9) == 0) begin
        add_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        n++;
      end else begin
        s = rand_lexeme();
        if ($urandom_range(3) != 0) s = {s, " "};
        add_text(s, $urandom_range(12) == 0);
        n += s.len();
      end
    end
  endtask

  // sender: present the queue head, change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          char_code <= byte_q[0].ch;
          is_last <= byte_q[0].fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_cycles <= HoldLen;
        out_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // monitor: predict on accepted bytes, check accepted tokens
  always @(posedge clk) begin
    tok_t e;
    bit   moved;
    if (rst) begin
      lex_reset();
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      moved = (in_valid && !in_stall) || (out_valid && !out_stall);
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_tokens(char_code, is_last);
        void'(byte_q.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("token with no prediction: kind %0d", token_kind);
          errors++;
        end else begin
          e = token_q.pop_front();
          if (token_kind !== e.kind) begin
            $error("token_kind exp %0d got %0d", e.kind, token_kind); errors++;
          end
          if (start_offset !== e.start) begin
            $error("start_offset exp %0d got %0d", e.start, start_offset); errors++;
          end
          if (token_length !== e.len) begin
            $error("token_length exp %0d got %0d", e.len, token_length); errors++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, last_of_run); errors++;
          end
        end
      end
      if (quiet_cycles >= WdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    while (byte_q.size() > 0 || token_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: every operator, keywords, numbers, strings, flushes
    add_text("if(x1==2.5){y=z;}else while !a != b <= c >= d -> e ** f && g || h\n", 0);
    add_text("true false and or not + ~ ^ - * / & | < > ", 0);
    add_text("'str' 1.2.3 // cmt\n\t", 0);
    add_byte(8'h00, 0); add_byte(8'hFF, 0); add_byte(8'h0D, 0);
    add_text("'open", 1);
    add_text("x //tail", 1);
    add_text("a<", 1);
    add_text("12", 1);
    add_byte(8'h00, 1);

    add_random(75);
    // long receiver hold-off while bytes keep arriving
    while (byte_q.size() >= 60) @(posedge clk);
    hold_req = 1;
    wait_drain();

    send_idle_pct = 50; recv_idle_pct = 25;
    add_random(75);
    wait_drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    add_random(65);
    add_byte(" ", 1);
    wait_drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
